[design/ibot_pkg.sv]
// Shared types and constants for the interval booking overlap table.
// Used by ibot_ctrl, ibot_dp, the top level and the checker; no dependencies.
`default_nettype none

package ibot_pkg;

    // Default table depth and time width
    localparam int ENTRIES_DEF   = 16;
    localparam int TIME_BITS_DEF = 32;

    // Port widths fixed by the word layout
    localparam int FIELD_W = 32;
    localparam int IN_W    = 2 * FIELD_W;
    localparam int OUT_W   = 8;

    // Result codes
    typedef enum logic [1:0] {
        ST_BOOKED  = 2'd0,
        ST_OVERLAP = 2'd1,
        ST_FULL    = 2'd2,
        ST_INVALID = 2'd3
    } status_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;   // latch a new request, restart the scan
        logic scan;      // walk the stored slots
        logic commit;    // load result word, store interval if booked
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic scan_done; // verdict known
        logic out_free;  // output register can take a word this cycle
    } dp_stat_t;

endpackage

`default_nettype wire

[design/interval_booking_overlap_table.sv]
// Top level of the interval booking overlap table.
// Joins ibot_ctrl and ibot_dp; depends on ibot_pkg.
//
//  channel  dir  word                                  accepted when
//  s_*      in   tdata[31:0] start_time, [63:32] end    s_tvalid && s_tready
//  m_*      out  tdata[0] booked, [2:1] status, pad 0   m_tvalid && m_tready
//
// One request at a time. A request is compared with each stored interval in
// turn: the slots are read one per cycle through the slot memory's single
// read port. An invalid request ends the scan at once, and an overlap found in
// a slot ends it early; the result word is loaded after the scan.
// The next request can be accepted in the same cycle as the result word appears.
// Reset clears the fill count and the output valid; no clearing pass.
// A waiting result word does not block the next request's scan; the commit
// waits until the output register is free.
`default_nettype none

module interval_booking_overlap_table #(
    parameter int ENTRIES   = ibot_pkg::ENTRIES_DEF,
    parameter int TIME_BITS = ibot_pkg::TIME_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [ibot_pkg::IN_W-1:0]  s_tdata,   // start_time, end_time
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [ibot_pkg::OUT_W-1:0]      m_tdata    // booked, status[1:0], zeros
);

    ibot_pkg::ctrl_cmd_t cmd;
    ibot_pkg::dp_stat_t  stat;

    ibot_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ibot_dp #(
        .ENTRIES   (ENTRIES),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

[design/ibot_ctrl.sv]
// Controller state machine for the interval booking overlap table.
// Depends on ibot_pkg for the command and status structs.
`default_nettype none

module ibot_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire ibot_pkg::dp_stat_t stat,
    output ibot_pkg::ctrl_cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Ready only between requests
    assign s_tready = (state_reg == S_IDLE);

    // Command decode
    always_comb
    begin
        cmd.capture = s_tvalid && (state_reg == S_IDLE);
        cmd.scan    = (state_reg == S_SCAN);
        cmd.commit  = (state_reg == S_FINISH) && stat.out_free;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

[design/ibot_dp.sv]
// Datapath: request registers, slot memory, scan counter, overlap compare,
// fill count and output register. Depends on ibot_pkg.
`default_nettype none

module ibot_dp #(
    parameter int ENTRIES   = ibot_pkg::ENTRIES_DEF,
    parameter int TIME_BITS = ibot_pkg::TIME_BITS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [ibot_pkg::IN_W-1:0] in_data,   // start_time, end_time
    input  wire ibot_pkg::ctrl_cmd_t       cmd,
    output ibot_pkg::dp_stat_t             stat,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [ibot_pkg::OUT_W-1:0]     m_tdata    // booked, status[1:0]
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int WIDE_W = 64;
    localparam int PAD_W = ibot_pkg::OUT_W - 3;

    // Slot memory: {end, start} per slot; slots 0..count-1 are in use
    logic [2*TIME_BITS-1:0] slot_mem [ENTRIES];
    logic [2*TIME_BITS-1:0] rd_data_reg;

    logic [TIME_BITS-1:0] req_start_reg, req_start_next;
    logic [TIME_BITS-1:0] req_end_reg, req_end_next;
    logic [CNT_W-1:0]     rd_idx_reg, rd_idx_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic                 hit_reg, hit_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [ibot_pkg::OUT_W-1:0] m_tdata_reg, m_tdata_next;

    logic [WIDE_W-1:0]    start_wide, end_wide;
    logic [TIME_BITS-1:0] rd_start, rd_end;
    logic                 issue, invalid, full, overlap, store;
    ibot_pkg::status_t    result;

    // Keep the low TIME_BITS of each field
    assign start_wide = {{(WIDE_W - ibot_pkg::FIELD_W){1'b0}},
                         in_data[ibot_pkg::FIELD_W-1:0]};
    assign end_wide   = {{(WIDE_W - ibot_pkg::FIELD_W){1'b0}},
                         in_data[ibot_pkg::IN_W-1:ibot_pkg::FIELD_W]};

    assign rd_start = rd_data_reg[TIME_BITS-1:0];
    assign rd_end   = rd_data_reg[2*TIME_BITS-1:TIME_BITS];

    assign invalid = (req_end_reg <= req_start_reg);
    assign full    = (count_reg == CNT_W'(ENTRIES));
    assign issue   = cmd.scan && (rd_idx_reg != count_reg);
    assign overlap = rd_pend_reg && (rd_start < req_end_reg) && (req_start_reg < rd_end);

    // Verdict, in priority order
    always_comb
    begin
        if (invalid)
            result = ibot_pkg::ST_INVALID;
        else if (hit_reg)
            result = ibot_pkg::ST_OVERLAP;
        else if (full)
            result = ibot_pkg::ST_FULL;
        else
            result = ibot_pkg::ST_BOOKED;
    end

    assign store = cmd.commit && (result == ibot_pkg::ST_BOOKED);

    assign stat.scan_done = invalid || hit_reg || ((rd_idx_reg == count_reg) && !rd_pend_reg);
    assign stat.out_free  = !m_tvalid_reg || m_tready;

    // Next values
    always_comb
    begin
        req_start_next = req_start_reg;
        req_end_next   = req_end_reg;
        rd_idx_next    = rd_idx_reg;
        rd_pend_next   = issue;
        hit_next       = hit_reg || overlap;
        count_next     = count_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;

        if (cmd.capture)
        begin
            req_start_next = start_wide[TIME_BITS-1:0];
            req_end_next   = end_wide[TIME_BITS-1:0];
            rd_idx_next    = '0;
            rd_pend_next   = 1'b0;
            hit_next       = 1'b0;
        end
        else if (issue)
        begin
            rd_idx_next = rd_idx_reg + 1'b1;
        end

        if (cmd.commit)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {{PAD_W{1'b0}}, result,
                             (result == ibot_pkg::ST_BOOKED)};
        end

        if (store)
            count_next = count_reg + 1'b1;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg   <= '0;
            rd_pend_reg  <= 1'b0;
            hit_reg      <= 1'b0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            rd_idx_reg   <= rd_idx_next;
            rd_pend_reg  <= rd_pend_next;
            hit_reg      <= hit_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_start_reg <= req_start_next;
        req_end_reg   <= req_end_next;
        m_tdata_reg   <= m_tdata_next;
    end

    // Slot memory: one write port at the fill count, one registered read port
    always_ff @(posedge clk)
    begin
        if (store)
            slot_mem[count_reg[IDX_W-1:0]] <= {req_end_reg, req_start_reg};
        rd_data_reg <= slot_mem[rd_idx_reg[IDX_W-1:0]];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

[design/ibot_checker.sv]
// Port-level checks for the interval booking overlap table, bound to the top.
// Depends on ibot_pkg for port widths and result codes.
`default_nettype none

module ibot_checker (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      s_tvalid,
    input wire logic                      s_tready,
    input wire logic                      m_tvalid,
    input wire logic                      m_tready,
    input wire logic [ibot_pkg::OUT_W-1:0] m_tdata
);

    // A stalled word stays valid
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    // A stalled word keeps its value
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result word changed while stalled");

    // Booked flag agrees with the status code
    a_booked_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[0] == (m_tdata[2:1] == ibot_pkg::ST_BOOKED)))
        else $error("booked flag disagrees with status");

    // One request at a time: no acceptance right after an acceptance
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while another is in work");

endmodule

bind interval_booking_overlap_table ibot_checker u_ibot_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
